### src/spht_pkg.sv
package spht_pkg;

	localparam int unsigned PC_W     = 21;
	localparam int unsigned ADDR_W   = 48;
	localparam int unsigned OFF_W    = 5;
	localparam int unsigned BITS_W   = 32;
	localparam int unsigned STAMP_W  = 32;
	localparam int unsigned CFG_IDX_W = 2;

	// blocks per region follow the width of the access bit vectors
	localparam int unsigned BLOCKS_PER_REGION = BITS_W;

	localparam logic CMD_INSERT = 1'b0;
	localparam logic CMD_LOOKUP = 1'b1;

	localparam logic [CFG_IDX_W-1:0] REG_ROTATE   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SEPARATE = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SATURATE = 2'd2;

	typedef struct packed {
		logic              command;
		logic [PC_W-1:0]   pc;
		logic [ADDR_W-1:0] block_address;
		logic [OFF_W-1:0]  trigger_offset;
		logic [BITS_W-1:0] access_bits;
		logic [BITS_W-1:0] read_bits;
		logic              is_read;
		logic [STAMP_W-1:0] stamp;
	} req_t;

	typedef struct packed {
		logic [ADDR_W-1:0] prefetch_address;
		logic              address_valid;
		logic              hit;
		logic              last;
	} rsp_t;

	typedef struct packed {
		logic rotate;
		logic separate;
		logic saturate;
	} cfg_t;

	// train one 2-bit counter
	function automatic logic [1:0] train(input logic [1:0] c, input logic b, input logic sat);
		logic [1:0] r;
		if (!sat) r = b ? 2'd2 : 2'd1;
		else if (b) r = (c == 2'd3) ? 2'd3 : c + 2'd1;
		else r = (c == 2'd0) ? 2'd0 : c - 2'd1;
		return r;
	endfunction

endpackage

### src/spht_mem.sv
module spht_mem #(
	parameter int unsigned DEPTH = 2048,
	parameter int unsigned WIDTH = 8
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	// one write port, one registered read port
	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		if (re) rdata <= mem[raddr];
	end
endmodule

### src/spatial_pattern_history_table_core.sv
// Spatial pattern history table: set-associative spatial prefetch predictor.
// Input channel (in_valid/in_ready, payload in_data) takes one request: an
// insert trains or allocates a way, a lookup predicts prefetch addresses.
// Output channel (out_valid/out_ready, payload out_data) gives the results
// of a lookup, one per predicted block in ascending order, last set on the
// final one; a miss or an empty pattern gives one result without an address.
// An insert gives no result.
// Sequence: an insert is accepted with the set memory read, then the read
// data is taken, then tags are compared and a way chosen with write back,
// in a single read-modify-write pass over the set row. A lookup miss loads
// its result in the write-back step, waiting there while a result is untaken.
// A lookup hit then scans one block a cycle while the output is free, from
// block 0 up to the last predicted block; an empty pattern scans every block
// and then gives its result. One request is in flight at a time.
// Reset clears the configuration registers and starts a clearing pass that
// writes every set row to zero with in_ready low; tags, stamps and counters
// then read as zero until written. When out_ready is low the result register
// holds and the scan waits; no result is lost.
// Configuration: cfg_we writes register cfg_index with cfg_data at once.
module spatial_pattern_history_table_core #(
	parameter int unsigned SETS = 256,
	parameter int unsigned WAYS = 8,
	parameter int unsigned PC_KEY_BITS = 16
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  spht_pkg::req_t          in_data,
	output logic                    out_valid,
	input  logic                    out_ready,
	output spht_pkg::rsp_t          out_data,
	input  logic                    cfg_we,
	input  logic [spht_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [0:0]              cfg_data
);
	import spht_pkg::*;

	localparam int unsigned OB    = $clog2(BLOCKS_PER_REGION);
	localparam int unsigned SB    = (SETS > 1) ? $clog2(SETS) : 1;
	localparam int unsigned SBR   = $clog2(SETS);
	localparam int unsigned KEY_W = PC_KEY_BITS + OB;
	localparam int unsigned TAG_W = (KEY_W > SBR) ? KEY_W - SBR : 1;
	localparam int unsigned WB    = (WAYS > 1) ? $clog2(WAYS) : 1;
	localparam int unsigned CW    = 2 * BLOCKS_PER_REGION;
	localparam int unsigned ENT_W = TAG_W + STAMP_W + 2 * CW;
	localparam int unsigned ROW_W = WAYS + WAYS * ENT_W;

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_READ  = 3'd1;
	localparam logic [2:0] ST_WB    = 3'd2;
	localparam logic [2:0] ST_SCAN  = 3'd3;
	localparam logic [2:0] ST_CLEAR = 3'd4;

	logic [2:0] state_q;
	logic [SB-1:0] clr_q;
	cfg_t cfg_q;
	req_t req_q;
	logic [OB-1:0] off_q;
	logic [SB-1:0] set_q;
	logic [TAG_W-1:0] tag_q;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) cfg_q <= '0;
		else if (cfg_we) begin
			case (cfg_index)
				REG_ROTATE:   cfg_q.rotate   <= cfg_data[0];
				REG_SEPARATE: cfg_q.separate <= cfg_data[0];
				REG_SATURATE: cfg_q.saturate <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// key from request
	logic [OB-1:0] in_off;
	logic [KEY_W-1:0] in_key;
	logic [63:0] pc_ext;
	always_comb begin
		pc_ext = 64'(in_data.pc);
		in_off = (in_data.command == CMD_LOOKUP) ? in_data.block_address[OB-1:0]
			: OB'(in_data.trigger_offset);
		if (cfg_q.rotate) in_key = pc_ext[KEY_W-1:0];
		else in_key = {pc_ext[PC_KEY_BITS-1:0], in_off};
	end

	// set row memory: valid bits, then per way tag, stamp, two counter patterns
	logic row_we;
	logic [ROW_W-1:0] row_wdata, row_rdata;
	logic [SB-1:0] rd_set, wr_set;
	assign rd_set = (SETS > 1) ? SB'(in_key) : '0;
	assign wr_set = (state_q == ST_CLEAR) ? clr_q : set_q;

	spht_mem #(.DEPTH(SETS < 2 ? 2 : SETS), .WIDTH(ROW_W)) u_row (
		.clk(clk), .we(row_we), .waddr($clog2(SETS < 2 ? 2 : SETS)'(wr_set)),
		.wdata(row_wdata), .re(in_valid && in_ready),
		.raddr($clog2(SETS < 2 ? 2 : SETS)'(rd_set)), .rdata(row_rdata)
	);

	// unpack row
	logic [WAYS-1:0]    vrow;
	logic [TAG_W-1:0]   w_tag   [WAYS];
	logic [STAMP_W-1:0] w_stamp [WAYS];
	logic [CW-1:0]      w_ar    [WAYS];
	logic [CW-1:0]      w_wr    [WAYS];
	assign vrow = row_rdata[WAYS*ENT_W +: WAYS];
	always_comb begin
		for (int w = 0; w < WAYS; w++) begin
			{w_tag[w], w_stamp[w], w_ar[w], w_wr[w]} = row_rdata[w*ENT_W +: ENT_W];
		end
	end

	// hit and victim select
	logic found;
	logic [WB-1:0] hit_way, vic_way, sel_way;
	logic empty;
	logic [STAMP_W-1:0] lru_ts;
	always_comb begin
		found = 1'b0; hit_way = '0; empty = 1'b0; vic_way = '0; lru_ts = '0;
		for (int w = WAYS-1; w >= 0; w--) begin
			if (vrow[w] && w_tag[w] == tag_q) begin
				found = 1'b1; hit_way = WB'(w);
			end
		end
		for (int w = 0; w < WAYS; w++) begin
			if (!empty) begin
				if (!vrow[w]) begin
					empty = 1'b1; vic_way = WB'(w);
				end else if (w == 0 || w_stamp[w] < lru_ts) begin
					lru_ts = w_stamp[w]; vic_way = WB'(w);
				end
			end
		end
		sel_way = found ? hit_way : vic_way;
	end

	// new counter patterns for insert
	logic [CW-1:0] new_ar, new_wr, old_ar, old_wr;
	logic [BITS_W-1:0] acc, rd;
	logic [OB-1:0] jj;
	logic a, r;
	always_comb begin
		old_ar = w_ar[sel_way];
		old_wr = w_wr[sel_way];
		acc = req_q.access_bits;
		rd = req_q.read_bits;
		new_ar = old_ar; new_wr = old_wr;
		for (int i = 0; i < BLOCKS_PER_REGION; i++) begin
			jj = cfg_q.rotate ? OB'(i) + off_q : OB'(i);
			a = acc[jj];
			r = rd[jj];
			if (!found) begin
				if (cfg_q.separate) begin
					new_ar[2*i +: 2] = (a && r) ? 2'd2 : 2'd1;
					new_wr[2*i +: 2] = (a && !r) ? 2'd2 : 2'd1;
				end else begin
					new_ar[2*i +: 2] = a ? 2'd2 : 2'd1;
				end
			end else if (cfg_q.separate) begin
				new_ar[2*i +: 2] = train(old_ar[2*i +: 2], r, cfg_q.saturate);
				new_wr[2*i +: 2] = train(old_wr[2*i +: 2], a && !r, cfg_q.saturate);
			end else begin
				new_ar[2*i +: 2] = train(old_ar[2*i +: 2], a, cfg_q.saturate);
			end
		end
	end

	// write-back row, or a zero row during the clearing pass
	always_comb begin
		row_wdata = row_rdata;
		row_we = 1'b0;
		if (state_q == ST_CLEAR) begin
			row_we = 1'b1;
			row_wdata = '0;
		end else if (state_q == ST_WB) begin
			if (req_q.command == CMD_INSERT) begin
				row_we = 1'b1;
				row_wdata[sel_way*ENT_W +: ENT_W] = {tag_q, req_q.stamp, new_ar, new_wr};
				row_wdata[WAYS*ENT_W + sel_way] = 1'b1;
			end else if (found) begin
				row_we = 1'b1;
				row_wdata[sel_way*ENT_W +: ENT_W] =
					{w_tag[sel_way], req_q.stamp, old_ar, old_wr};
			end
		end
	end

	// scan state
	logic [CW-1:0] pat_q;
	logic hit_q, any_q;
	logic [OB:0] j_q;
	logic [OB-1:0] src;
	logic [1:0] cnt;
	logic out_free;
	assign out_free = !out_valid || out_ready;
	assign src = cfg_q.rotate ? j_q[OB-1:0] - off_q : j_q[OB-1:0];
	assign cnt = pat_q[2*src +: 2];
	assign in_ready = (state_q == ST_IDLE);

	// a later counter with its upper bit set exists
	logic more;
	logic [OB:0] jn;
	logic [OB-1:0] sn;
	always_comb begin
		more = 1'b0;
		for (int k = 0; k < BLOCKS_PER_REGION; k++) begin
			jn = (OB+1)'(k);
			sn = cfg_q.rotate ? OB'(k) - off_q : OB'(k);
			if (jn > j_q && pat_q[2*sn+1]) more = 1'b1;
		end
	end

	// a result is loaded into the output register this cycle
	logic emit;
	always_comb begin
		emit = 1'b0;
		if (state_q == ST_WB && req_q.command == CMD_LOOKUP && !found && out_free)
			emit = 1'b1;
		if (state_q == ST_SCAN && out_free) begin
			if (j_q == (OB+1)'(BLOCKS_PER_REGION)) emit = !any_q;
			else emit = cnt[1];
		end
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_q <= '0;
			out_valid <= 1'b0;
		end else begin
			if (emit) out_valid <= 1'b1;
			else if (out_ready) out_valid <= 1'b0;
			case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == SB'(SETS - 1)) state_q <= ST_IDLE;
				end
				ST_IDLE: if (in_valid) state_q <= ST_READ;
				ST_READ: state_q <= ST_WB;
				ST_WB: begin
					if (req_q.command == CMD_INSERT) state_q <= ST_IDLE;
					else if (found) state_q <= ST_SCAN;
					else if (out_free) state_q <= ST_IDLE;
				end
				ST_SCAN: begin
					if (out_free) begin
						if (j_q == (OB+1)'(BLOCKS_PER_REGION)) state_q <= ST_IDLE;
						else if (cnt[1] && !more) state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			req_q <= in_data;
			off_q <= in_off;
			set_q <= rd_set;
			tag_q <= TAG_W'(in_key >> SBR);
		end
		if (state_q == ST_WB) begin
			hit_q <= found;
			any_q <= 1'b0;
			j_q <= '0;
			pat_q <= (cfg_q.separate && !req_q.is_read) ? old_wr : old_ar;
			if (req_q.command == CMD_LOOKUP && !found && out_free)
				out_data <= '{prefetch_address: '0, address_valid: 1'b0,
					hit: 1'b0, last: 1'b1};
		end
		if (state_q == ST_SCAN && out_free) begin
			if (j_q == (OB+1)'(BLOCKS_PER_REGION)) begin
				out_data <= '{prefetch_address: '0, address_valid: 1'b0,
					hit: hit_q, last: 1'b1};
			end else begin
				if (cnt[1] && !more) j_q <= (OB+1)'(BLOCKS_PER_REGION);
				else j_q <= j_q + 1'b1;
				if (cnt[1]) begin
					any_q <= 1'b1;
					out_data <= '{prefetch_address: {req_q.block_address[ADDR_W-1:OB],
						j_q[OB-1:0]}, address_valid: 1'b1, hit: 1'b1, last: !more};
				end
			end
		end
	end
endmodule

### tb/spatial_pattern_history_table_core_tb.sv
`timescale 1ns / 100ps

module spatial_pattern_history_table_core_tb;
	import spht_pkg::*;

	localparam int NUM_ENTRIES = 2048;
	localparam int NUM_BLOCKS  = 32;
	localparam int NUM_WAYS    = 8;

	// prefetch predictor with its own copy of the table and configuration
	class prefetch_predictor;
		bit          ent_valid [NUM_ENTRIES];
		bit          wr_written [NUM_ENTRIES];
		bit [12:0]   ent_tag [NUM_ENTRIES];
		bit [31:0]   ent_stamp [NUM_ENTRIES];
		bit [63:0]   acc_cnt [NUM_ENTRIES];
		bit [63:0]   wr_cnt [NUM_ENTRIES];
		bit          rotate, separate, saturate;
		rsp_t        expected_prefetches [$];
		int          mismatches, n_results, n_lookups, n_inserts, n_hits;

		function int pending();
			return expected_prefetches.size();
		endfunction

		function void set_config(bit rot, bit sep, bit sat);
			rotate = rot;
			separate = sep;
			saturate = sat;
		endfunction

		function bit [1:0] step_counter(bit [1:0] c, bit b);
			if (!saturate) return b ? 2'd2 : 2'd1;
			if (b) return (c == 2'd3) ? 2'd3 : c + 2'd1;
			return (c == 2'd0) ? 2'd0 : c - 2'd1;
		endfunction

		function bit [4:0] offset_of(req_t r);
			return (r.command == CMD_LOOKUP) ? r.block_address[4:0] : r.trigger_offset;
		endfunction

		function bit [20:0] key_of(req_t r);
			return rotate ? r.pc : {r.pc[15:0], offset_of(r)};
		endfunction

		// index of the matching entry, or -1
		function int find_entry(req_t r);
			bit [20:0] key;
			int e;
			key = key_of(r);
			for (int w = 0; w < NUM_WAYS; w++) begin
				e = key[7:0] * NUM_WAYS + w;
				if (ent_valid[e] && ent_tag[e] == key[20:8]) return e;
			end
			return -1;
		endfunction

		// true when the request would read a write pattern never filled
		function bit touches_unwritten(req_t r);
			int e;
			e = find_entry(r);
			if (e < 0 || !separate || wr_written[e]) return 1'b0;
			return (r.command == CMD_INSERT) || !r.is_read;
		endfunction

		function void note_request(req_t r);
			bit [20:0] key;
			bit [4:0]  off, j, src;
			bit [1:0]  c;
			bit        a, rd, found;
			int        e, base_e;
			rsp_t      res;
			rsp_t      preds [$];
			key = key_of(r);
			off = offset_of(r);
			e = find_entry(r);
			found = (e >= 0);
			base_e = key[7:0] * NUM_WAYS;
			if (r.command == CMD_INSERT) begin
				n_inserts++;
				if (!found) begin
					// first empty way, else smallest stamp, lowest way on a tie
					e = base_e;
					for (int w = 0; w < NUM_WAYS; w++) begin
						if (!ent_valid[base_e + w]) begin
							e = base_e + w;
							break;
						end
						if (ent_stamp[base_e + w] < ent_stamp[e]) e = base_e + w;
					end
					ent_valid[e] = 1'b1;
					ent_tag[e] = key[20:8];
					wr_written[e] = separate;
				end
				for (int i = 0; i < NUM_BLOCKS; i++) begin
					j = rotate ? 5'(i + off) : 5'(i);
					a = r.access_bits[j];
					rd = r.read_bits[j];
					if (!found) begin
						if (separate) begin
							acc_cnt[e][2*i +: 2] = a ? (rd ? 2'd2 : 2'd1) : 2'd1;
							wr_cnt[e][2*i +: 2] = a ? (rd ? 2'd1 : 2'd2) : 2'd1;
						end else begin
							acc_cnt[e][2*i +: 2] = a ? 2'd2 : 2'd1;
						end
					end else if (separate) begin
						acc_cnt[e][2*i +: 2] = step_counter(acc_cnt[e][2*i +: 2], rd);
						wr_cnt[e][2*i +: 2] = step_counter(wr_cnt[e][2*i +: 2], a && !rd);
					end else begin
						acc_cnt[e][2*i +: 2] = step_counter(acc_cnt[e][2*i +: 2], a);
					end
				end
				ent_stamp[e] = r.stamp;
				return;
			end
			n_lookups++;
			if (found) begin
				n_hits++;
				ent_stamp[e] = r.stamp;
				for (int i = 0; i < NUM_BLOCKS; i++) begin
					j = 5'(i);
					src = rotate ? 5'(j - off) : j;
					c = (separate && !r.is_read) ? wr_cnt[e][2*src +: 2]
						: acc_cnt[e][2*src +: 2];
					if (c >= 2) begin
						res.prefetch_address = {r.block_address[47:5], j};
						res.address_valid = 1'b1;
						res.hit = 1'b1;
						res.last = 1'b0;
						preds = {preds, res};
					end
				end
			end
			if (preds.size() == 0) begin
				res.prefetch_address = '0;
				res.address_valid = 1'b0;
				res.hit = found;
				res.last = 1'b1;
				preds = {preds, res};
			end else begin
				preds[preds.size()-1].last = 1'b1;
			end
			expected_prefetches = {expected_prefetches, preds};
		endfunction

		function void check_response(rsp_t got);
			rsp_t want;
			n_results++;
			if (expected_prefetches.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result addr=%h av=%0d hit=%0d last=%0d",
						got.prefetch_address, got.address_valid, got.hit, got.last);
				return;
			end
			want = expected_prefetches.pop_front();
			if (got.prefetch_address !== want.prefetch_address ||
			    got.address_valid !== want.address_valid ||
			    got.hit !== want.hit || got.last !== want.last) begin
				mismatches++;
				if (mismatches <= 10)
					$display({"mismatch: expected addr=%h av=%0d hit=%0d last=%0d,",
						" got addr=%h av=%0d hit=%0d last=%0d"},
						want.prefetch_address, want.address_valid, want.hit, want.last,
						got.prefetch_address, got.address_valid, got.hit, got.last);
			end
		endfunction
	endclass

	logic clk, arst_n;
	logic in_valid, in_ready, out_valid, out_ready;
	req_t in_data;
	rsp_t out_data;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [0:0] cfg_data;

	prefetch_predictor predictor;
	bit hold_request;
	bit [20:0] pc_pool [12];
	bit [4:0] off_pool [4];

	spatial_pattern_history_table_core u_top (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	// clock
	always begin
		clk = 1'b1;
		#10;
		clk = 1'b0;
		#10;
	end

	// result monitor
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) predictor.check_response(out_data);
	end

	// receiver stall pattern, with a long hold-off on request
	initial begin
		int hold_cnt, mode, cyc;
		hold_cnt = 0;
		mode = 0;
		cyc = 0;
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			cyc++;
			if (cyc % 64 == 0) mode = $urandom_range(0, 3);
			if (hold_request) begin
				hold_request = 1'b0;
				hold_cnt = 400;
			end
			if (hold_cnt > 0) begin
				hold_cnt--;
				out_ready <= 1'b0;
			end else begin
				case (mode)
					0: out_ready <= 1'b1;
					1: out_ready <= ($urandom_range(0, 9) < 7);
					2: out_ready <= (cyc % 5 != 0);
					default: out_ready <= ($urandom_range(0, 1) == 1);
				endcase
			end
		end
	end

	// run limit
	initial begin
		#20ms;
		$display("TB_ERROR");
		$finish;
	end

	task automatic send_request(req_t r);
		@(negedge clk);
		in_valid <= 1'b1;
		in_data <= r;
		do @(posedge clk); while (!in_ready);
		predictor.note_request(r);
	endtask

	task automatic idle_sender(int n);
		repeat (n) begin
			@(negedge clk);
			in_valid <= 1'b0;
		end
	endtask

	task automatic wait_drained();
		idle_sender(1);
		while (predictor.pending() != 0) @(posedge clk);
		repeat (60) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, bit val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic apply_config(bit rot, bit sep, bit sat);
		wait_drained();
		write_reg(REG_ROTATE, rot);
		write_reg(REG_SEPARATE, sep);
		write_reg(REG_SATURATE, sat);
		predictor.set_config(rot, sep, sat);
	endtask

	function automatic req_t make_request(bit cmd, bit [20:0] pc, bit [4:0] off,
		bit [31:0] acc, bit [31:0] rd, bit isr, bit [31:0] stamp);
		req_t r;
		r.command = cmd;
		r.pc = pc;
		r.block_address = {43'({$urandom, $urandom}), off};
		r.trigger_offset = off;
		r.access_bits = acc;
		r.read_bits = rd;
		r.is_read = isr;
		r.stamp = stamp;
		return r;
	endfunction

	// mostly keys from a small pool so inserts and lookups meet
	function automatic req_t random_request();
		req_t r;
		bit [20:0] pc;
		bit [4:0] off;
		bit [31:0] acc;
		pc = ($urandom_range(0, 9) < 8) ? pc_pool[$urandom_range(0, 11)] : 21'($urandom);
		off = ($urandom_range(0, 9) < 8) ? off_pool[$urandom_range(0, 3)] : 5'($urandom);
		case ($urandom_range(0, 5))
			0: acc = '1;
			1: acc = '0;
			default: acc = $urandom;
		endcase
		r = make_request(1'($urandom_range(0, 1)), pc, off, acc, $urandom,
			1'($urandom_range(0, 1)), $urandom);
		r.trigger_offset = ($urandom_range(0, 9) == 0) ? 5'($urandom) : off;
		if (r.command == CMD_INSERT && $urandom_range(0, 4) == 0)
			r.block_address = 48'({$urandom, $urandom});
		return r;
	endfunction

	task automatic random_phase(int n, bit with_pause);
		req_t r;
		int burst;
		burst = 0;
		for (int i = 0; i < n; i++) begin
			do r = random_request(); while (predictor.touches_unwritten(r));
			if (burst == 0) begin
				idle_sender($urandom_range(0, 6));
				burst = $urandom_range(1, 8);
			end
			burst--;
			send_request(r);
			if (with_pause && i == n / 2) wait_drained();
		end
	endtask

	initial begin
		bit [20:0] lru_pc;
		predictor = new();
		hold_request = 1'b0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		for (int k = 0; k < 12; k++) pc_pool[k] = {13'(k * 37 + 1), 8'h5A};
		off_pool[0] = 5'd0;
		off_pool[1] = 5'd7;
		off_pool[2] = 5'd31;
		off_pool[3] = 5'd18;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: extremes, empty pattern, miss, LRU with equal stamps
		apply_config(1'b0, 1'b0, 1'b0);
		send_request(make_request(CMD_LOOKUP, 21'h1FFFFF, 5'd31, '0, '0, 1'b1, '1));
		send_request(make_request(CMD_INSERT, 21'h1FFFFF, 5'd31, '1, '1, 1'b0, '1));
		send_request(make_request(CMD_LOOKUP, 21'h1FFFFF, 5'd31, '0, '0, 1'b0, 32'd0));
		send_request(make_request(CMD_INSERT, 21'd0, 5'd0, '0, '0, 1'b1, 32'd0));
		send_request(make_request(CMD_LOOKUP, 21'd0, 5'd0, '0, '0, 1'b1, 32'd1));
		send_request(make_request(CMD_INSERT, 21'd0, 5'd0, 32'h8000_0001, '0, 1'b0, 32'd2));
		send_request(make_request(CMD_LOOKUP, 21'd0, 5'd0, '0, '0, 1'b1, 32'd3));
		for (int k = 0; k < 9; k++) begin
			lru_pc = {13'(k + 100), 8'h03};
			send_request(make_request(CMD_INSERT, lru_pc, 5'd3, $urandom, $urandom, 1'b0,
				32'd5));
		end
		send_request(make_request(CMD_LOOKUP, {13'd100, 8'h03}, 5'd3, '0, '0, 1'b1, 32'd9));
		send_request(make_request(CMD_LOOKUP, {13'd108, 8'h03}, 5'd3, '0, '0, 1'b1, 32'd9));
		send_request(make_request(CMD_LOOKUP, {13'd101, 8'h03}, 5'd3, '0, '0, 1'b0, 32'd9));

		// random phases across settings, including all off and all on
		random_phase(15, 1'b1);
		apply_config(1'b0, 1'b0, 1'b1);
		hold_request = 1'b1;
		random_phase(15, 1'b0);
		apply_config(1'b1, 1'b0, 1'b0);
		random_phase(15, 1'b0);
		apply_config(1'b1, 1'b1, 1'b1);
		random_phase(15, 1'b1);
		apply_config(1'b0, 1'b1, 1'b0);
		random_phase(15, 1'b0);
		apply_config(1'b0, 1'b1, 1'b1);
		hold_request = 1'b1;
		random_phase(15, 1'b0);
		apply_config(1'b1, 1'b0, 1'b1);
		random_phase(15, 1'b0);
		apply_config(1'b1, 1'b1, 1'b0);
		random_phase(15, 1'b0);

		wait_drained();
		repeat (100) @(posedge clk);
		if (predictor.pending() != 0) predictor.mismatches++;
		$display("covered %0d inserts and %0d lookups (%0d hits), %0d results checked",
			predictor.n_inserts, predictor.n_lookups, predictor.n_hits, predictor.n_results);
		$display("over eight register settings, %0d mismatches", predictor.mismatches);
		if (predictor.mismatches == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule

### filelist.f
src/spht_pkg.sv
src/spht_mem.sv
src/spatial_pattern_history_table_core.sv
tb/spatial_pattern_history_table_core_tb.sv
